// ----- hw/rtl/ubfi_pkg.sv -----
`timescale 1ns / 1ps

package ubfi_pkg;

	// frame filter constants
	localparam logic [31:0] L2L3_EXPECTED = 32'h0800_4511;
	localparam logic [31:0] SRC_ADDR      = 32'h0a0a_0f02;
	localparam logic [31:0] DST_ADDR      = 32'h0a0a_0f03;
	localparam logic [15:0] UDP_PORT      = 16'd5602;
	localparam logic [15:0] UDP_LEN       = 16'd1480;
	localparam logic [31:0] MAGIC         = 32'h5043_414d;
	localparam logic [7:0]  RATE_MOD      = 8'd100;
	localparam logic [15:0] CSUM_ALL_ONES = 16'hffff;

	// register map, index = paddr[4:2]
	localparam int unsigned PADDR_W = 5;
	localparam logic [2:0] REG_ENABLED    = 3'd0;
	localparam logic [2:0] REG_TARGET_IDX = 3'd1;
	localparam logic [2:0] REG_RATE_PCT   = 3'd2;
	localparam logic [2:0] REG_FLIP_EN    = 3'd3;
	localparam logic [2:0] REG_RUN_ID     = 3'd4;

	typedef enum logic [2:0] {
		VERDICT_OFF          = 3'd0,
		VERDICT_SHORT        = 3'd1,
		VERDICT_NO_MATCH     = 3'd2,
		VERDICT_PLAIN        = 3'd3,
		VERDICT_OTHER_INDEX  = 3'd4,
		VERDICT_NOT_SELECTED = 3'd5,
		VERDICT_NO_FLIP      = 3'd6,
		VERDICT_MODIFIED     = 3'd7
	} verdict_t;

	typedef struct packed {
		logic        enabled;
		logic [15:0] target_packet_index;
		logic [7:0]  sel_pct;
		logic        flip_enable;
		logic [31:0] run_id;
	} cfg_t;

	// last field in the lowest bits
	typedef struct packed {
		logic [15:0] udp_checksum;
		logic [15:0] pay_word;
		logic [15:0] flag_bits;
		logic [15:0] pkt_index;
		logic [31:0] frame_num;
		logic [31:0] session_id;
		logic [31:0] magic_word;
		logic [47:0] udp_ports_len;
		logic [63:0] ip_addresses;
		logic [31:0] l2l3_word;
		logic        frame_short;
	} in_item_t;

	typedef struct packed {
		logic [31:0] last_run;
		logic [15:0] last_index;
		logic [31:0] last_frame;
		logic [31:0] last_session;
		logic [31:0] modified_total;
		logic [31:0] selected_total;
		logic [31:0] eligible_total;
		logic [31:0] parse_error_total;
		logic [15:0] checksum_out;
		logic [15:0] body_word_out;
		verdict_t    verdict;
	} out_item_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [15:0] body_word_out;
		logic [15:0] checksum_out;
		logic        parse_err;
		logic        eligible;
		logic        selected;
		logic        modified;
	} cls_t;

	localparam int unsigned IN_W        = $bits(in_item_t);
	localparam int unsigned OUT_W       = $bits(out_item_t);
	localparam int unsigned IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	// x mod 100 without a divider: fold bytes by 2^(8k) mod 100, then reciprocal
	function automatic logic [6:0] mod100(input logic [31:0] x);
		logic [14:0] x1;
		logic [12:0] x2;
		logic [25:0] prod;
		logic [6:0]  q;
		logic [12:0] r;
		x1 = 15'(x[7:0]) + 15'(x[15:8]) * 15'd56 + 15'(x[23:16]) * 15'd36
			+ 15'(x[31:24]) * 15'd16;
		x2 = 13'(x1[7:0]) + 13'(x1[14:8]) * 13'd56;
		prod = 26'(x2) * 26'd5243;
		q = prod[25:19];
		r = x2 - 13'(q) * 13'd100;
		return r[6:0];
	endfunction

	// one's complement 16-bit add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + 16'(s[16]);
	endfunction

endpackage

// ----- hw/rtl/ubfi_cfg_regs.sv -----
`timescale 1ns / 1ps

module ubfi_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ubfi_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output ubfi_pkg::cfg_t               cfg
);

	ubfi_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (paddr[4:2])
				ubfi_pkg::REG_ENABLED:    cfg_q.enabled <= pwdata[0];
				ubfi_pkg::REG_TARGET_IDX: cfg_q.target_packet_index <= pwdata[15:0];
				ubfi_pkg::REG_RATE_PCT:   cfg_q.sel_pct <= pwdata[7:0];
				ubfi_pkg::REG_FLIP_EN:    cfg_q.flip_enable <= pwdata[0];
				ubfi_pkg::REG_RUN_ID:     cfg_q.run_id <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			ubfi_pkg::REG_ENABLED:    prdata = {31'd0, cfg_q.enabled};
			ubfi_pkg::REG_TARGET_IDX: prdata = {16'd0, cfg_q.target_packet_index};
			ubfi_pkg::REG_RATE_PCT:   prdata = {24'd0, cfg_q.sel_pct};
			ubfi_pkg::REG_FLIP_EN:    prdata = {31'd0, cfg_q.flip_enable};
			ubfi_pkg::REG_RUN_ID:     prdata = cfg_q.run_id;
			default:                  prdata = 32'd0;
		endcase
	end

endmodule

// ----- hw/rtl/ubfi_classify.sv -----
`timescale 1ns / 1ps

module ubfi_classify (
	input  ubfi_pkg::cfg_t     cfg,
	input  ubfi_pkg::in_item_t item,
	output ubfi_pkg::cls_t     cls
);

	logic        hdr_ok;
	logic        rate_ok;
	logic [6:0]  frame_mod;
	logic [15:0] flipped;
	logic [15:0] csum_new;
	logic [15:0] csum_fix;

	assign hdr_ok = (item.l2l3_word == ubfi_pkg::L2L3_EXPECTED)
		&& (item.ip_addresses == {ubfi_pkg::SRC_ADDR, ubfi_pkg::DST_ADDR})
		&& (item.udp_ports_len == {ubfi_pkg::UDP_PORT, ubfi_pkg::UDP_PORT, ubfi_pkg::UDP_LEN})
		&& (item.magic_word == ubfi_pkg::MAGIC);

	assign frame_mod = ubfi_pkg::mod100(item.frame_num);
	assign rate_ok   = (cfg.sel_pct != 8'd0) && (cfg.sel_pct <= ubfi_pkg::RATE_MOD)
		&& ({1'b0, frame_mod} < cfg.sel_pct);

	// incremental update: ~(~chk + ~old + new)
	assign flipped  = item.pay_word ^ 16'h0001;
	assign csum_new = ~ubfi_pkg::oc_add(ubfi_pkg::oc_add(~item.udp_checksum, ~item.pay_word),
		flipped);
	assign csum_fix = (item.udp_checksum == 16'd0) ? 16'd0 :
		(csum_new == 16'd0) ? ubfi_pkg::CSUM_ALL_ONES : csum_new;

	always_comb begin
		cls.verdict       = ubfi_pkg::VERDICT_OFF;
		cls.body_word_out = item.pay_word;
		cls.checksum_out  = item.udp_checksum;
		cls.parse_err     = 1'b0;
		cls.eligible      = 1'b0;
		cls.selected      = 1'b0;
		cls.modified      = 1'b0;
		if (!cfg.enabled) begin
			cls.verdict = ubfi_pkg::VERDICT_OFF;
		end else if (item.frame_short) begin
			cls.verdict   = ubfi_pkg::VERDICT_SHORT;
			cls.parse_err = 1'b1;
		end else if (!hdr_ok) begin
			cls.verdict = ubfi_pkg::VERDICT_NO_MATCH;
		end else if (!item.flag_bits[0]) begin
			cls.verdict = ubfi_pkg::VERDICT_PLAIN;
		end else if (item.pkt_index != cfg.target_packet_index) begin
			cls.verdict = ubfi_pkg::VERDICT_OTHER_INDEX;
		end else begin
			cls.eligible = 1'b1;
			if (!rate_ok) begin
				cls.verdict = ubfi_pkg::VERDICT_NOT_SELECTED;
			end else begin
				cls.selected = 1'b1;
				if (!cfg.flip_enable) begin
					cls.verdict = ubfi_pkg::VERDICT_NO_FLIP;
				end else begin
					cls.verdict       = ubfi_pkg::VERDICT_MODIFIED;
					cls.modified      = 1'b1;
					cls.body_word_out = flipped;
					cls.checksum_out  = csum_fix;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/udp_frame_bit_flip_injector.sv -----
`timescale 1ns / 1ps
// throughput: one word per cycle, held back only when the output side stalls
// two register stages: input register, then classify/checksum logic into the result register
// reset (arst_n low, asynchronous): clears valids, configuration, counters and recorded ids

module udp_frame_bit_flip_injector (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ubfi_pkg::PADDR_W-1:0]         paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	// input words, one per frame
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// from bit 0: frame_short, l2l3_word, ip_addresses, udp_ports_len, magic_word,
	// session_id, frame_num, pkt_index, flag_bits, pay_word, udp_checksum, zero pad
	input  logic [ubfi_pkg::IN_TDATA_W-1:0]      s_tdata,
	// result words
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// from bit 0: verdict, body_word_out, checksum_out, parse_error_total,
	// eligible_total, selected_total, modified_total, last_session, last_frame,
	// last_index, last_run, zero pad
	output logic [ubfi_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	ubfi_pkg::cfg_t     cfg;
	ubfi_pkg::cls_t     cls;
	ubfi_pkg::in_item_t item_s1;
	logic               valid_s1;
	ubfi_pkg::out_item_t res_s2;
	logic               valid_s2;
	logic               advance;

	// running statistics and the ids of the latest eligible frame
	logic [31:0] parse_err_q;
	logic [31:0] eligible_q;
	logic [31:0] selected_q;
	logic [31:0] modified_q;
	logic [31:0] rec_session_q;
	logic [31:0] rec_frame_q;
	logic [15:0] rec_index_q;
	logic [31:0] rec_run_q;

	logic [31:0] parse_err_nx;
	logic [31:0] eligible_nx;
	logic [31:0] selected_nx;
	logic [31:0] modified_nx;
	logic [31:0] rec_session_nx;
	logic [31:0] rec_frame_nx;
	logic [15:0] rec_index_nx;
	logic [31:0] rec_run_nx;

	ubfi_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ubfi_classify u_cls (
		.cfg  (cfg),
		.item (item_s1),
		.cls  (cls)
	);

	// stage 1 moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= s_tdata[ubfi_pkg::IN_W-1:0];
		end
	end

	// counters wrap naturally at 32 bits
	assign parse_err_nx   = parse_err_q + 32'(cls.parse_err);
	assign eligible_nx    = eligible_q + 32'(cls.eligible);
	assign selected_nx    = selected_q + 32'(cls.selected);
	assign modified_nx    = modified_q + 32'(cls.modified);
	assign rec_session_nx = cls.eligible ? item_s1.session_id : rec_session_q;
	assign rec_frame_nx   = cls.eligible ? item_s1.frame_num : rec_frame_q;
	assign rec_index_nx   = cls.eligible ? item_s1.pkt_index : rec_index_q;
	assign rec_run_nx     = cls.eligible ? cfg.run_id : rec_run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_err_q   <= '0;
			eligible_q    <= '0;
			selected_q    <= '0;
			modified_q    <= '0;
			rec_session_q <= '0;
			rec_frame_q   <= '0;
			rec_index_q   <= '0;
			rec_run_q     <= '0;
		end else if (advance) begin
			parse_err_q   <= parse_err_nx;
			eligible_q    <= eligible_nx;
			selected_q    <= selected_nx;
			modified_q    <= modified_nx;
			rec_session_q <= rec_session_nx;
			rec_frame_q   <= rec_frame_nx;
			rec_index_q   <= rec_index_nx;
			rec_run_q     <= rec_run_nx;
		end
	end

	// result register, reports the statistics as they stand after this frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2.verdict           <= cls.verdict;
			res_s2.body_word_out     <= cls.body_word_out;
			res_s2.checksum_out      <= cls.checksum_out;
			res_s2.parse_error_total <= parse_err_nx;
			res_s2.eligible_total    <= eligible_nx;
			res_s2.selected_total    <= selected_nx;
			res_s2.modified_total    <= modified_nx;
			res_s2.last_session      <= rec_session_nx;
			res_s2.last_frame        <= rec_frame_nx;
			res_s2.last_index        <= rec_index_nx;
			res_s2.last_run          <= rec_run_nx;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {(ubfi_pkg::OUT_TDATA_W - ubfi_pkg::OUT_W)'(0), res_s2};

endmodule

// ----- hw/rtl/ubfi_checker.sv -----
`timescale 1ns / 1ps

module ubfi_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [ubfi_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// input only backs up when the output side is full and stalled
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// an accepted word reaches the output when the output is free
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 (!m_tvalid || m_tready) |=> m_tvalid)
		else $error("accepted word did not reach the output");

endmodule

bind udp_frame_bit_flip_injector ubfi_checker u_ubfi_checker (.*);
